FILE: src/hrlp_pkg.sv
// Package for the HTTP request line parser: payload types, status and phase
// codes, and the method and version text tables. No dependencies.

package hrlp_pkg;

    localparam int HRLP_MAX_LINE = 8192;
    localparam int NUM_METHODS   = 16;
    localparam int VERSION_LEN   = 5;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } line_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  method;
        logic [12:0] target_offset;
        logic [12:0] target_length;
    } line_result_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_LONG    = 3'd1,
        STATUS_TOO_SHORT   = 3'd2,
        STATUS_BAD_METHOD  = 3'd3,
        STATUS_BAD_VERSION = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        PH_METHOD      = 6'b000001,
        PH_TARGET      = 6'b000010,
        PH_VERSION     = 6'b000100,
        PH_DONE        = 6'b001000,
        PH_BAD_METHOD  = 6'b010000,
        PH_BAD_VERSION = 6'b100000
    } phase_t;

    // Method names with their trailing space, right-aligned in 80 bits.
    localparam logic [79:0] METHOD_TEXT [NUM_METHODS] = '{
        "DELETE ", "GET ", "POST ", "PUT ", "PATCH ", "PROPFIND ",
        "PROPPATCH ", "REPORT ", "HEAD ", "OPTIONS ", "TRACE ", "MKCOL ",
        "MOVE ", "COPY ", "LOCK ", "UNLOCK "
    };

    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd7, 4'd4, 4'd5, 4'd4, 4'd6, 4'd9, 4'd10, 4'd7,
        4'd5, 4'd8, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd7
    };

    localparam logic [39:0] VERSION_TEXT = "HTTP/";

    // Character idx of method m; meaningful only for idx below its length.
    function automatic logic [7:0] method_char(input logic [3:0] m, input logic [3:0] idx);
        logic [3:0]  back;
        logic [79:0] text;
        back = METHOD_LEN[m] - 4'd1 - idx;
        text = METHOD_TEXT[m] >> {back, 3'b000};
        return text[7:0];
    endfunction

    // Character idx of "HTTP/"; meaningful only for idx below five.
    function automatic logic [7:0] version_char(input logic [2:0] idx);
        logic [2:0]  back;
        logic [39:0] text;
        back = 3'd4 - idx;
        text = VERSION_TEXT >> {back, 3'b000};
        return text[7:0];
    endfunction

endpackage

FILE: src/hrlp_stream_if.sv
// Valid/ready stream interface used for both channels of the request line
// parser. The payload type is set per instance; no other dependencies.

interface hrlp_stream_if #(parameter type payload_t = logic [0:0]);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: src/http_request_line_parser.sv
// HTTP request line parser: top level and only module.
// Depends on hrlp_pkg and on hrlp_stream_if.
//
// The request_line channel carries one byte of a request line per request,
// with end_of_line set on the last byte; trailing whitespace is already
// stripped. For each line one result leaves on parse_result: a status, the
// method code, and the offset and length of the request target.
// A byte is first held in an input register and is parsed from there, where
// it updates a handful of small state registers and, on the last byte,
// loads the result register. A result is valid once its last byte has left
// the input register; one byte is accepted in every cycle but for the stall below.
// While a result waits in the result register, ordinary bytes keep flowing;
// only the next end-of-line byte holds in the input register, and then
// request_line.ready drops until the result is taken.
// Reset clears both registers' valid flags and returns the parser to the
// start of a line. Bytes at position MAX_LINE and beyond are not parsed.

module http_request_line_parser
    import hrlp_pkg::*;
#(
    parameter int MAX_LINE = HRLP_MAX_LINE
) (
    input  logic         clk,
    input  logic         rst_n,
    hrlp_stream_if.sink   request_line,
    hrlp_stream_if.source parse_result
);

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(MAX_LINE - 1);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic [NUM_METHODS-1:0] cand_reg,   cand_next;
    phase_t                 phase_reg,  phase_next;
    logic [3:0]             method_reg, method_next;
    logic [12:0]            begin_reg,  begin_next;
    logic [12:0]            count_reg,  count_next;
    logic [2:0]             vidx_reg,   vidx_next;
    logic                   vok_reg,    vok_next;

    logic         out_valid_reg;
    line_result_t out_data_reg, out_data_next;

    logic         slot_free;
    logic         proc_fire;
    logic         accept;
    logic         active;
    logic [12:0]  target_pos;

    assign slot_free = !out_valid_reg || parse_result.ready;
    assign proc_fire = in_valid_reg && (!in_last_reg || slot_free);
    assign accept    = request_line.valid && request_line.ready;
    assign active    = pos_reg < POS_LIMIT;
    assign target_pos = 13'(pos_reg);

    assign request_line.ready  = !in_valid_reg || proc_fire;
    assign parse_result.valid  = out_valid_reg;
    assign parse_result.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request_line.ready)
        begin
            in_valid_reg <= request_line.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= request_line.payload.line_byte;
            in_last_reg <= request_line.payload.end_of_line;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        phase_next  = phase_reg;
        method_next = method_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        vidx_next   = vidx_reg;
        vok_next    = vok_reg;

        if (active)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_METHOD:
                begin
                    for (int i = 0; i < NUM_METHODS; i++)
                    begin
                        if (cand_reg[i])
                        begin
                            if (pos_reg >= POS_W'(METHOD_LEN[i]) ||
                                method_char(4'(i), pos_reg[3:0]) != in_byte_reg)
                            begin
                                cand_next[i] = 1'b0;
                            end
                            else if (pos_reg == POS_W'(METHOD_LEN[i] - 4'd1))
                            begin
                                method_next = 4'(i);
                                begin_next  = target_pos + 13'd1;
                                phase_next  = PH_TARGET;
                            end
                        end
                    end
                    if (phase_next == PH_METHOD && cand_next == '0)
                    begin
                        phase_next = PH_BAD_METHOD;
                    end
                end
                PH_TARGET:
                begin
                    if (in_byte_reg == 8'h20)
                    begin
                        count_next = target_pos - begin_reg;
                        vidx_next  = 3'd0;
                        phase_next = PH_VERSION;
                    end
                end
                PH_VERSION:
                begin
                    if (vidx_reg < 3'(VERSION_LEN) && version_char(vidx_reg) == in_byte_reg)
                    begin
                        vidx_next = vidx_reg + 3'd1;
                        if (vidx_next == 3'(VERSION_LEN))
                        begin
                            vok_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_BAD_VERSION;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_data_next = '0;
        if (pos_reg >= LAST_POS)
        begin
            out_data_next.status = STATUS_TOO_LONG;
        end
        else if (pos_reg < POS_W'(4))
        begin
            out_data_next.status = STATUS_TOO_SHORT;
        end
        else if (phase_next == PH_METHOD || phase_next == PH_BAD_METHOD)
        begin
            out_data_next.status = STATUS_BAD_METHOD;
        end
        else if (phase_next != PH_DONE || !vok_next)
        begin
            out_data_next.status = STATUS_BAD_VERSION;
            out_data_next.method = method_next;
        end
        else
        begin
            out_data_next.status        = STATUS_OK;
            out_data_next.method        = method_next;
            out_data_next.target_offset = begin_next;
            out_data_next.target_length = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cand_reg   <= '1;
            phase_reg  <= PH_METHOD;
            method_reg <= 4'd0;
            begin_reg  <= 13'd0;
            count_reg  <= 13'd0;
            vidx_reg   <= 3'd0;
            vok_reg    <= 1'b0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                pos_reg    <= '0;
                cand_reg   <= '1;
                phase_reg  <= PH_METHOD;
                method_reg <= 4'd0;
                begin_reg  <= 13'd0;
                count_reg  <= 13'd0;
                vidx_reg   <= 3'd0;
                vok_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                cand_reg   <= cand_next;
                phase_reg  <= phase_next;
                method_reg <= method_next;
                begin_reg  <= begin_next;
                count_reg  <= count_next;
                vidx_reg   <= vidx_next;
                vok_reg    <= vok_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (parse_result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A parsed end-of-line byte always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_last_reg |=> out_valid_reg)
    else $error("end of line parsed without a result");

    // A finished line returns the parser to the start of the next line.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_last_reg |=> pos_reg == '0 && phase_reg == PH_METHOD)
    else $error("parser state not cleared after end of line");

    // An end-of-line byte that finds the result still waiting stalls the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && out_valid_reg && !parse_result.ready
        |-> !request_line.ready)
    else $error("input accepted while a result blocks the parser");

    // Only a good line reports a target.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != STATUS_OK
        |-> out_data_reg.target_offset == 13'd0 && out_data_reg.target_length == 13'd0)
    else $error("target reported for a failed line");

endmodule

FILE: sim/tb_http_request_line_parser.sv
// Testbench for http_request_line_parser: sends request lines one byte per request and
// compares every parse result with the outcome of a line parser kept in the testbench.
// Depends on hrlp_pkg, hrlp_stream_if and the parser RTL.

module tb_http_request_line_parser
    import hrlp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD       = 10;
    localparam int          LINE_LIMIT       = 8192;
    localparam int          RANDOM_BYTES     = 1350;
    localparam int          MIN_RANDOM_LINES = 30;
    localparam int          QUIET_LIMIT      = 1000;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          REPORT_LIMIT     = 10;
    localparam int          MAX_GAP          = 13;
    localparam logic [7:0]  SPACE_CHAR       = 8'h20;

    typedef logic [7:0] text_t[$];

    class line_outcome_board;
        logic [13:0]  position;
        logic [15:0]  candidates;
        phase_t       phase;
        logic [3:0]   found_method;
        logic [12:0]  target_start;
        logic [12:0]  target_span;
        logic [2:0]   version_pos;
        bit           version_seen;
        string        method_names[16];
        string        version_word;
        line_result_t expected_q[$];
        int           errors;
        int           lines;
        int           checked;
        int           status_tally[5];

        function new();
            method_names = '{"DELETE ", "GET ", "POST ", "PUT ", "PATCH ", "PROPFIND ",
                             "PROPPATCH ", "REPORT ", "HEAD ", "OPTIONS ", "TRACE ",
                             "MKCOL ", "MOVE ", "COPY ", "LOCK ", "UNLOCK "};
            version_word = "HTTP/";
            errors = 0;
            lines = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            position = '0;
            candidates = '1;
            phase = PH_METHOD;
            found_method = '0;
            target_start = '0;
            target_span = '0;
            version_pos = '0;
            version_seen = 1'b0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void parse_char(int at, logic [7:0] value);
            int name_len;
            case (phase)
                PH_METHOD:
                begin
                    for (int m = 0; m < 16; m++)
                    begin
                        name_len = method_names[m].len();
                        if (candidates[m])
                        begin
                            if (at >= name_len || method_names[m][at] != value)
                                candidates[m] = 1'b0;
                            else if (at + 1 == name_len)
                            begin
                                found_method = 4'(m);
                                target_start = 13'(at + 1);
                                phase = PH_TARGET;
                            end
                        end
                    end
                    if (phase == PH_METHOD && candidates == '0)
                        phase = PH_BAD_METHOD;
                end
                PH_TARGET:
                begin
                    if (value == SPACE_CHAR)
                    begin
                        target_span = 13'(at) - target_start;
                        version_pos = '0;
                        phase = PH_VERSION;
                    end
                end
                PH_VERSION:
                begin
                    if (version_pos < 3'd5 && version_word[version_pos] == value)
                    begin
                        version_pos++;
                        if (version_pos == 3'd5)
                        begin
                            version_seen = 1'b1;
                            phase = PH_DONE;
                        end
                    end
                    else
                        phase = PH_BAD_VERSION;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_request(line_req_t req);
            int           at;
            status_t      verdict;
            line_result_t outcome;
            at = position;
            if (at < LINE_LIMIT)
            begin
                parse_char(at, req.line_byte);
                position = 14'(at + 1);
            end
            if (!req.end_of_line)
                return;
            outcome = '0;
            if (at + 1 >= LINE_LIMIT)
                verdict = STATUS_TOO_LONG;
            else if (at + 1 < 5)
                verdict = STATUS_TOO_SHORT;
            else if (phase == PH_METHOD || phase == PH_BAD_METHOD)
                verdict = STATUS_BAD_METHOD;
            else if (phase != PH_DONE || !version_seen)
            begin
                verdict = STATUS_BAD_VERSION;
                outcome.method = found_method;
            end
            else
            begin
                verdict = STATUS_OK;
                outcome.method = found_method;
                outcome.target_offset = target_start;
                outcome.target_length = target_span;
            end
            outcome.status = verdict;
            expected_q.push_back(outcome);
            status_tally[verdict]++;
            lines++;
            restart();
        endfunction

        function void check_result(line_result_t got);
            line_result_t want;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("Unexpected result: status %0d method %0d offset %0d length %0d",
                               got.status, got.method, got.target_offset, got.target_length));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status || got.method !== want.method ||
                got.target_offset !== want.target_offset ||
                got.target_length !== want.target_length)
                flag($sformatf({"Line %0d: expected status %0d method %0d offset %0d ",
                                "length %0d, got status %0d method %0d offset %0d length %0d"},
                               checked, want.status, want.method, want.target_offset,
                               want.target_length, got.status, got.method,
                               got.target_offset, got.target_length));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    bit                send_calm;
    bit                take_calm;
    int                bytes_sent;
    int                quiet_cycles = 0;
    line_outcome_board board = new();

    hrlp_stream_if #(.payload_t(line_req_t))    request_line ();
    hrlp_stream_if #(.payload_t(line_result_t)) parse_result ();

    http_request_line_parser #(.MAX_LINE(LINE_LIMIT)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .request_line (request_line),
        .parse_result (parse_result)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    function automatic void add_text(ref text_t t, input string s);
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
    endfunction

    function automatic logic [7:0] target_char();
        logic [7:0] value;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(33, 126));
        do
            value = 8'($urandom_range(0, 255));
        while (value == SPACE_CHAR);
        return value;
    endfunction

    // Mostly well-formed lines with random content; the rest are corrupted,
    // cut short or pure noise.
    function automatic text_t random_line();
        text_t t;
        int    kind;
        int    span;
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            span = $urandom_range(1, 20);
            repeat (span) t.push_back(8'($urandom_range(0, 255)));
            return t;
        end
        add_text(t, board.method_names[$urandom_range(0, 15)]);
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        repeat (span) t.push_back(target_char());
        add_text(t, " HTTP/1.");
        t.push_back(8'($urandom_range(48, 57)));
        if (kind >= 80)
            t = t[0:$urandom_range(0, t.size() - 1)];
        else if (kind >= 70)
            t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        return t;
    endfunction

    task automatic send_byte(logic [7:0] value, logic last);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            request_line.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_line.valid   <= 1'b1;
        request_line.payload <= '{line_byte: value, end_of_line: last};
        do
            @(posedge clk);
        while (!request_line.ready);
        board.note_request(request_line.payload);
        bytes_sent++;
    endtask

    task automatic send_line(text_t t);
        for (int i = 0; i < t.size(); i++)
            send_byte(t[i], i == t.size() - 1);
    endtask

    task automatic hold_off();
        request_line.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        string directed[$];
        text_t t;
        int    random_from_bytes;
        int    random_from_lines;
        bit    paused;
        rst_n                <= 1'b0;
        request_line.valid   <= 1'b0;
        request_line.payload <= '0;
        send_calm = 1'b0;
        bytes_sent = 0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{"DELETE /a HTTP/1.1", "GET / HTTP/1.0", "POST /p HTTP/1.1",
                     "PUT /q HTTP/1.1", "PATCH /r HTTP/1.1", "PROPFIND /s HTTP/1.1",
                     "PROPPATCH /t HTTP/1.1", "REPORT /u HTTP/1.1", "HEAD /v HTTP/1.1",
                     "OPTIONS * HTTP/1.1", "TRACE /w HTTP/1.1", "MKCOL /x HTTP/1.1",
                     "MOVE /y HTTP/1.1", "COPY /z HTTP/1.1", "LOCK /l HTTP/1.1",
                     "UNLOCK /k HTTP/1.1", "G", "GET ", "GET /", "PROPFIND",
                     "GETX / HTTP/1.1", "GET  HTTP/1.1", "GET /a HTTP", "GET /a HTTX/1.1",
                     "GET /a"};
        foreach (directed[i])
        begin
            t.delete();
            add_text(t, directed[i]);
            send_line(t);
        end
        t = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20};
        send_line(t);
        hold_off();

        random_from_bytes = bytes_sent;
        random_from_lines = board.lines;
        while (bytes_sent - random_from_bytes < RANDOM_BYTES ||
               board.lines - random_from_lines < MIN_RANDOM_LINES)
        begin
            send_calm = ($urandom_range(0, 4) == 0);
            send_line(random_line());
            if (!paused && bytes_sent - random_from_bytes >= RANDOM_BYTES / 2)
            begin
                hold_off();
                paused = 1'b1;
            end
        end
        request_line.valid <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
            board.flag($sformatf("%0d results never arrived", board.outstanding()));

        $display("Sent %0d request lines in %0d bytes, %0d lines of them random.",
                 board.lines, bytes_sent, board.lines - random_from_lines);
        $display({"Outcomes: %0d ok, %0d too long, %0d too short, %0d unknown method, ",
                  "%0d bad version; %0d mismatches."},
                 board.status_tally[STATUS_OK], board.status_tally[STATUS_TOO_LONG],
                 board.status_tally[STATUS_TOO_SHORT], board.status_tally[STATUS_BAD_METHOD],
                 board.status_tally[STATUS_BAD_VERSION], board.errors);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int gap;
        take_calm = 1'b0;
        parse_result.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                take_calm = !take_calm;
            gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                parse_result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            parse_result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!parse_result.valid);
            board.check_result(parse_result.payload);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_line.valid && request_line.ready) ||
            (parse_result.valid && parse_result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
src/hrlp_pkg.sv
src/hrlp_stream_if.sv
src/http_request_line_parser.sv
sim/tb_http_request_line_parser.sv
